/* sv/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// All macros sample on aclk and are switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ppmrc_pkg.sv */
// ----------------------------------------------------------------------------
// ppmrc_pkg: shared types and constants of the PPM channel decoder
// Configuration record, register indexes, slot and result types.
// ----------------------------------------------------------------------------
package ppmrc_pkg;

    // Transaction kinds on the input stream (tuser)
    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_SYNC_THRESHOLD = 3'd0,
        REG_LOST_LOW       = 3'd1,
        REG_LOST_HIGH      = 3'd2,
        REG_DZ_ROLL_PITCH  = 3'd3,
        REG_DZ_YAW         = 3'd4,
        REG_SWITCH_MID     = 3'd5,
        REG_THREE_POS_LOW  = 3'd6,
        REG_THREE_POS_HIGH = 3'd7
    } reg_idx_t;

    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;
    localparam int SLOT_W   = 12;
    localparam int MAP_CH   = 8;
    // Measured width: 16-bit microseconds plus an overflow bit
    localparam int WIDTH_W  = 17;

    localparam logic [SLOT_W-1:0] SLOT_MAX    = 12'd4095;
    localparam logic [SLOT_W-1:0] THR_BASE    = 12'd1000;
    localparam logic [SLOT_W-1:0] THR_TOP     = 12'd2000;
    localparam logic [9:0]        THR_FULL    = 10'd1000;
    localparam logic signed [12:0] ATT_CENTRE = 13'sd1500;
    localparam logic signed [12:0] ATT_LIMIT  = 13'sd1500;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_SYNC_THRESHOLD = 16'd3000;
    localparam logic [11:0] RST_LOST_LOW       = 12'd800;
    localparam logic [11:0] RST_LOST_HIGH      = 12'd2200;
    localparam logic [10:0] RST_DZ_ROLL_PITCH  = 11'd10;
    localparam logic [10:0] RST_DZ_YAW         = 11'd15;
    localparam logic [11:0] RST_SWITCH_MID     = 12'd1500;
    localparam logic [11:0] RST_THREE_POS_LOW  = 12'd1300;
    localparam logic [11:0] RST_THREE_POS_HIGH = 12'd1700;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic signed [11:0] att_t;
    typedef slot_t [MAP_CH-1:0] map_ch_t;

    typedef struct packed {
        logic [15:0] sync_threshold_us;
        logic [11:0] lost_low_us;
        logic [11:0] lost_high_us;
        logic [10:0] deadzone_roll_pitch;
        logic [10:0] yaw_deadband;
        logic [11:0] switch_mid_us;
        logic [11:0] three_pos_low_us;
        logic [11:0] three_pos_high_us;
    } cfg_t;

    // Result record: last member lands in the lowest bits of tdata
    typedef struct packed {
        logic       manual_hold;
        logic       rc_lost;
        logic       switch_d;
        logic [1:0] switch_c;
        logic       switch_b;
        logic       switch_a;
        att_t       yaw_steps;
        att_t       pitch_steps;
        att_t       roll_steps;
        logic [9:0] throttle_tenths;
    } res_t;

    localparam int RES_W   = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

/* sv/ppmrc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ppmrc_cfg_regs: APB configuration registers
// Eight threshold registers, written on the APB access phase, read back
// through a plain address decode.
// ----------------------------------------------------------------------------
module ppmrc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppmrc_pkg::CFG_AW-1:0]   paddr,
    input  logic [ppmrc_pkg::CFG_DW-1:0]   pwdata,
    output logic [ppmrc_pkg::CFG_DW-1:0]   prdata,
    output logic                           pready,
    output ppmrc_pkg::cfg_t                cfg
);

    ppmrc_pkg::cfg_t      cfg_reg;
    ppmrc_pkg::reg_idx_t  reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = ppmrc_pkg::reg_idx_t'(paddr[ppmrc_pkg::CFG_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_threshold_us   <= ppmrc_pkg::RST_SYNC_THRESHOLD;
            cfg_reg.lost_low_us         <= ppmrc_pkg::RST_LOST_LOW;
            cfg_reg.lost_high_us        <= ppmrc_pkg::RST_LOST_HIGH;
            cfg_reg.deadzone_roll_pitch <= ppmrc_pkg::RST_DZ_ROLL_PITCH;
            cfg_reg.yaw_deadband        <= ppmrc_pkg::RST_DZ_YAW;
            cfg_reg.switch_mid_us       <= ppmrc_pkg::RST_SWITCH_MID;
            cfg_reg.three_pos_low_us    <= ppmrc_pkg::RST_THREE_POS_LOW;
            cfg_reg.three_pos_high_us   <= ppmrc_pkg::RST_THREE_POS_HIGH;
        end else if (wr_en) begin
            case (reg_idx)
                ppmrc_pkg::REG_SYNC_THRESHOLD: cfg_reg.sync_threshold_us   <= pwdata[15:0];
                ppmrc_pkg::REG_LOST_LOW:       cfg_reg.lost_low_us         <= pwdata[11:0];
                ppmrc_pkg::REG_LOST_HIGH:      cfg_reg.lost_high_us        <= pwdata[11:0];
                ppmrc_pkg::REG_DZ_ROLL_PITCH:  cfg_reg.deadzone_roll_pitch <= pwdata[10:0];
                ppmrc_pkg::REG_DZ_YAW:         cfg_reg.yaw_deadband        <= pwdata[10:0];
                ppmrc_pkg::REG_SWITCH_MID:     cfg_reg.switch_mid_us       <= pwdata[11:0];
                ppmrc_pkg::REG_THREE_POS_LOW:  cfg_reg.three_pos_low_us    <= pwdata[11:0];
                ppmrc_pkg::REG_THREE_POS_HIGH: cfg_reg.three_pos_high_us   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            ppmrc_pkg::REG_SYNC_THRESHOLD: prdata = {16'd0, cfg_reg.sync_threshold_us};
            ppmrc_pkg::REG_LOST_LOW:       prdata = {20'd0, cfg_reg.lost_low_us};
            ppmrc_pkg::REG_LOST_HIGH:      prdata = {20'd0, cfg_reg.lost_high_us};
            ppmrc_pkg::REG_DZ_ROLL_PITCH:  prdata = {21'd0, cfg_reg.deadzone_roll_pitch};
            ppmrc_pkg::REG_DZ_YAW:         prdata = {21'd0, cfg_reg.yaw_deadband};
            ppmrc_pkg::REG_SWITCH_MID:     prdata = {20'd0, cfg_reg.switch_mid_us};
            ppmrc_pkg::REG_THREE_POS_LOW:  prdata = {20'd0, cfg_reg.three_pos_low_us};
            ppmrc_pkg::REG_THREE_POS_HIGH: prdata = {20'd0, cfg_reg.three_pos_high_us};
            default:                       prdata = '0;
        endcase
    end

endmodule

/* sv/ppmrc_width_meas.sv */
// ----------------------------------------------------------------------------
// ppmrc_width_meas: pulse width measurement
// Subtracts the previous edge timestamp, then divides the tick count by the
// tick rate with a reciprocal multiply. Widths of 65536 us or more are
// flagged in the top bit.
// ----------------------------------------------------------------------------
module ppmrc_width_meas #(
    parameter int TICKS_PER_US = 80
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [31:0]                       edge_time,
    input  logic                              take_edge,
    input  logic                              ld_diff,
    input  logic                              ld_width,
    output logic [ppmrc_pkg::WIDTH_W-1:0]     width
);

    // Dividend bits needed below the overflow limit (65536 us)
    localparam int DIV_N = 24;
    localparam int DIV_L = $clog2(TICKS_PER_US);
    localparam int DIV_S = DIV_N + DIV_L;
    localparam int MUL_W = DIV_N + 1;
    localparam int PROD_W = DIV_N + MUL_W;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_S) + longint'(TICKS_PER_US) - 64'd1) / longint'(TICKS_PER_US);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(DIV_M);
    localparam logic [31:0] OVF_TICKS = 32'(65536 * TICKS_PER_US);

    logic [31:0]                    prev_edge_reg;
    logic [31:0]                    diff_reg;
    logic [31:0]                    diff_next;
    logic [PROD_W-1:0]              prod;
    logic                           ovf;
    logic [ppmrc_pkg::WIDTH_W-1:0]  width_reg;
    logic [ppmrc_pkg::WIDTH_W-1:0]  width_next;

    assign diff_next = edge_time - prev_edge_reg;

    // Track the timestamp of the last edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_edge_reg <= '0;
        end else if (take_edge) begin
            prev_edge_reg <= edge_time;
        end
    end

    // Hold the tick difference
    always_ff @(posedge aclk) begin
        if (ld_diff) begin
            diff_reg <= diff_next;
        end
    end

    // Divide by the tick rate; exact for every dividend below 2^DIV_N
    assign prod = {{MUL_W{1'b0}}, diff_reg[DIV_N-1:0]} * {{DIV_N{1'b0}}, RECIP};
    assign ovf  = (diff_reg >= OVF_TICKS);

    always_comb begin
        if (ovf) begin
            width_next = {1'b1, 16'd0};
        end else begin
            width_next = {1'b0, prod[DIV_S +: 16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_width) begin
            width_reg <= width_next;
        end
    end

    assign width = width_reg;

endmodule

/* sv/ppmrc_chan_map.sv */
// ----------------------------------------------------------------------------
// ppmrc_chan_map: channel to control mapping
// Turns the stored channel widths into throttle, attitude steps, switch
// positions and the signal-lost flag.
// ----------------------------------------------------------------------------
module ppmrc_chan_map (
    input  ppmrc_pkg::map_ch_t  ch,
    input  logic                armed,
    input  ppmrc_pkg::cfg_t     cfg,
    output ppmrc_pkg::res_t     res
);

    // Offset from centre, zeroed inside the deadzone, clipped at the top
    function automatic ppmrc_pkg::att_t attitude(ppmrc_pkg::slot_t w, logic [10:0] zone);
        logic signed [12:0] v;
        logic [12:0]        mag;
        ppmrc_pkg::att_t    r;
        v   = $signed({1'b0, w}) - ppmrc_pkg::ATT_CENTRE;
        mag = v[12] ? 13'(-v) : 13'(v);
        if (mag < {2'b00, zone}) begin
            r = '0;
        end else if (v > ppmrc_pkg::ATT_LIMIT) begin
            r = ppmrc_pkg::att_t'(ppmrc_pkg::ATT_LIMIT);
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

    logic       sw_a;
    logic [1:0] sw_c;
    logic [9:0] thr;

    // Clamp throttle to the 1000..2000 us band
    always_comb begin
        if (ch[2] <= ppmrc_pkg::THR_BASE) begin
            thr = '0;
        end else if (ch[2] > ppmrc_pkg::THR_TOP) begin
            thr = ppmrc_pkg::THR_FULL;
        end else begin
            thr = 10'(ch[2] - ppmrc_pkg::THR_BASE);
        end
    end

    // Three-position switch on channel six
    always_comb begin
        if (ch[6] < cfg.three_pos_low_us) begin
            sw_c = 2'd0;
        end else if (ch[6] <= cfg.three_pos_high_us) begin
            sw_c = 2'd1;
        end else begin
            sw_c = 2'd2;
        end
    end

    assign sw_a = (ch[4] > cfg.switch_mid_us);

    // Assemble the result record
    always_comb begin
        res.throttle_tenths = thr;
        res.roll_steps      = attitude(ch[0], cfg.deadzone_roll_pitch);
        res.pitch_steps     = attitude(ch[1], cfg.deadzone_roll_pitch);
        res.yaw_steps       = attitude(ch[3], cfg.yaw_deadband);
        res.switch_a        = sw_a;
        res.switch_b        = (ch[5] > cfg.switch_mid_us);
        res.switch_c        = sw_c;
        res.switch_d        = (ch[7] > cfg.switch_mid_us);
        res.rc_lost         = armed &&
                              ((ch[0] < cfg.lost_low_us) || (ch[0] > cfg.lost_high_us));
        res.manual_hold     = sw_a;
    end

endmodule

/* sv/ppm_rc_channel_decoder.sv */
// ----------------------------------------------------------------------------
// ppm_rc_channel_decoder: PPM radio-control decoder with channel mapping
// Measures pulse widths from capture edges, fills the channel slots and
// maps them to control values on a poll transaction.
//
//   Port group   Dir   Carries
//   s_axis       in    tuser: op; tdata: edge_time[31:0], armed[32]
//   m_axis       out   tdata: mapped controls (53 bits in 56)
//   apb          in    eight configuration registers at 4*index
//
// One transaction is accepted per cycle while s_tready is high; a poll
// goes through subtract, reciprocal multiply, then map into the output
// register, where m_tvalid rises. The multiply stage sets the clock limit.
// Edge transactions give no result. A stalled output fills the three inner
// stages before s_tready drops. Synchronous reset clears all control state,
// the timestamp, the channel index and every slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppm_rc_channel_decoder #(
    parameter int NUM_CHANNELS = 8,
    parameter int TICKS_PER_US = 80
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tuser: op
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [39:0]                          s_tdata,   // edge_time[31:0], armed[32]
    input  logic                                 s_tuser,   // op[0]
    // tdata: throttle_tenths, roll_steps, pitch_steps, yaw_steps, switch_a,
    // switch_b, switch_c, switch_d, rc_lost, manual_hold
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ppmrc_pkg::M_TDATA_W-1:0]      m_tdata,   // throttle[9:0] .. hold[52]
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ppmrc_pkg::CFG_AW-1:0]         paddr,
    input  logic [ppmrc_pkg::CFG_DW-1:0]         pwdata,
    output logic [ppmrc_pkg::CFG_DW-1:0]         prdata,
    output logic                                 pready
);

    localparam int IW  = $clog2(NUM_CHANNELS + 1);
    localparam int SIW = $clog2(NUM_CHANNELS);

    ppmrc_pkg::cfg_t                 cfg;
    ppmrc_pkg::res_t                 map_res;
    ppmrc_pkg::map_ch_t              map_ch;

    // Stage registers
    logic                            v1_reg, v2_reg, v3_reg;
    ppmrc_pkg::op_t                  op1_reg, op2_reg, op3_reg;
    logic                            armed1_reg, armed2_reg, armed3_reg;
    logic [31:0]                     edge1_reg;
    logic                            rdy1, rdy2, rdy3, out_free;
    logic                            ld_diff, ld_width, take_edge;
    logic [ppmrc_pkg::WIDTH_W-1:0]   width;

    // Channel store
    logic [IW-1:0]                   chan_idx_reg;
    ppmrc_pkg::slot_t                slot_reg [NUM_CHANNELS];
    logic                            edge_commit, is_sync;
    ppmrc_pkg::slot_t                slot_next;

    // Output register
    logic                            m_tvalid_reg;
    ppmrc_pkg::res_t                 m_res_reg;
    logic                            poll_out;

    ppmrc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage handshakes: a stage may load when it is empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;
    assign rdy3     = !v3_reg || (op3_reg == ppmrc_pkg::OP_EDGE) || out_free;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign ld_diff   = rdy2 && v1_reg;
    assign ld_width  = rdy3 && v2_reg;
    assign take_edge = ld_diff && (op1_reg == ppmrc_pkg::OP_EDGE);

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Advance the transaction sideband
    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            op1_reg    <= ppmrc_pkg::op_t'(s_tuser);
            edge1_reg  <= s_tdata[31:0];
            armed1_reg <= s_tdata[32];
        end
        if (ld_diff) begin
            op2_reg    <= op1_reg;
            armed2_reg <= armed1_reg;
        end
        if (ld_width) begin
            op3_reg    <= op2_reg;
            armed3_reg <= armed2_reg;
        end
    end

    ppmrc_width_meas #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_width (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edge_time (edge1_reg),
        .take_edge (take_edge),
        .ld_diff   (ld_diff),
        .ld_width  (ld_width),
        .width     (width)
    );

    // Store the pulse in the next slot, restart on a sync pulse
    assign edge_commit = v3_reg && (op3_reg == ppmrc_pkg::OP_EDGE);
    assign is_sync     = (width > {1'b0, cfg.sync_threshold_us});
    assign slot_next   = (width > {5'd0, ppmrc_pkg::SLOT_MAX}) ? ppmrc_pkg::SLOT_MAX
                                                               : width[ppmrc_pkg::SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_idx_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (edge_commit) begin
            if (is_sync) begin
                chan_idx_reg <= '0;
            end else if (chan_idx_reg < IW'(NUM_CHANNELS)) begin
                slot_reg[chan_idx_reg[SIW-1:0]] <= slot_next;
                chan_idx_reg <= chan_idx_reg + 1'b1;
            end
        end
    end

    // Present the mapped slots
    always_comb begin
        for (int i = 0; i < ppmrc_pkg::MAP_CH; i++) begin
            map_ch[i] = slot_reg[i];
        end
    end

    ppmrc_chan_map u_map (
        .ch    (map_ch),
        .armed (armed3_reg),
        .cfg   (cfg),
        .res   (map_res)
    );

    // Load the output register on a poll, drop valid once taken
    assign poll_out = v3_reg && (op3_reg == ppmrc_pkg::OP_POLL) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (poll_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (poll_out) begin
            m_res_reg <= map_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(ppmrc_pkg::M_TDATA_W - ppmrc_pkg::RES_W){1'b0}}, m_res_reg};

    // Checks
    `ASSERT_IMPLY(a_stall_only_full, !s_tready, v1_reg && v2_reg && v3_reg, "input stalled with an empty stage")
    `ASSERT_IMPLY(a_result_from_poll, $rose(m_tvalid_reg), $past(v3_reg && (op3_reg == ppmrc_pkg::OP_POLL)), "result without a poll")
    `ASSERT_NEXT(a_sync_restart, edge_commit && is_sync, chan_idx_reg == '0, "sync pulse did not restart the frame")
    `ASSERT_IMPLY(a_idx_step, chan_idx_reg != $past(chan_idx_reg), (chan_idx_reg == '0) || (chan_idx_reg == $past(chan_idx_reg) + 1'b1), "channel index jumped")

endmodule

/* dv/tb_ppm_rc_channel_decoder.sv */
// ----------------------------------------------------------------------------
// tb_ppm_rc_channel_decoder: self-checking bench for the PPM channel decoder
// Streams capture edges and polls into the decoder and predicts every mapped
// control transaction from its own copy of the slots and registers. It opens
// with directed frames (range limits, deadzones, switch edges, saturation,
// timer wrap), then runs random frames, noise and polls under several
// register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_ppm_rc_channel_decoder;

    localparam int NUM_SLOTS      = 8;
    localparam int TICKS          = 80;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // Predicts the slot contents and the mapped controls of each poll
    class channel_map_tracker;
        ppmrc_pkg::cfg_t   cfg;
        logic [31:0]       last_stamp;
        int                slot_ptr;
        ppmrc_pkg::slot_t  slots [NUM_SLOTS];
        ppmrc_pkg::res_t   pending_controls [$];
        int                errors;

        function new();
            cfg.sync_threshold_us   = ppmrc_pkg::RST_SYNC_THRESHOLD;
            cfg.lost_low_us         = ppmrc_pkg::RST_LOST_LOW;
            cfg.lost_high_us        = ppmrc_pkg::RST_LOST_HIGH;
            cfg.deadzone_roll_pitch = ppmrc_pkg::RST_DZ_ROLL_PITCH;
            cfg.yaw_deadband        = ppmrc_pkg::RST_DZ_YAW;
            cfg.switch_mid_us       = ppmrc_pkg::RST_SWITCH_MID;
            cfg.three_pos_low_us    = ppmrc_pkg::RST_THREE_POS_LOW;
            cfg.three_pos_high_us   = ppmrc_pkg::RST_THREE_POS_HIGH;
            last_stamp = '0;
            slot_ptr   = 0;
            foreach (slots[i]) slots[i] = '0;
            errors = 0;
        endfunction

        function void set_register(ppmrc_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                ppmrc_pkg::REG_SYNC_THRESHOLD: cfg.sync_threshold_us   = value[15:0];
                ppmrc_pkg::REG_LOST_LOW:       cfg.lost_low_us         = value[11:0];
                ppmrc_pkg::REG_LOST_HIGH:      cfg.lost_high_us        = value[11:0];
                ppmrc_pkg::REG_DZ_ROLL_PITCH:  cfg.deadzone_roll_pitch = value[10:0];
                ppmrc_pkg::REG_DZ_YAW:         cfg.yaw_deadband        = value[10:0];
                ppmrc_pkg::REG_SWITCH_MID:     cfg.switch_mid_us       = value[11:0];
                ppmrc_pkg::REG_THREE_POS_LOW:  cfg.three_pos_low_us    = value[11:0];
                ppmrc_pkg::REG_THREE_POS_HIGH: cfg.three_pos_high_us   = value[11:0];
                default: ;
            endcase
        endfunction

        // Centre the width, apply the deadzone on the full offset, then clip
        function ppmrc_pkg::att_t steer(ppmrc_pkg::slot_t w, logic [10:0] zone);
            int v;
            int mag;
            int z;
            v = w;
            v = v - 1500;
            z = zone;
            mag = (v < 0) ? -v : v;
            if (mag < z) v = 0;
            if (v > 1500) v = 1500;
            if (v < -1500) v = -1500;
            return v[11:0];
        endfunction

        function ppmrc_pkg::res_t map_slots(logic armed);
            ppmrc_pkg::res_t r;
            if (slots[2] <= 12'd1000)
                r.throttle_tenths = '0;
            else if (slots[2] > 12'd2000)
                r.throttle_tenths = 10'd1000;
            else
                r.throttle_tenths = 10'(slots[2] - 12'd1000);
            r.roll_steps  = steer(slots[0], cfg.deadzone_roll_pitch);
            r.pitch_steps = steer(slots[1], cfg.deadzone_roll_pitch);
            r.yaw_steps   = steer(slots[3], cfg.yaw_deadband);
            r.switch_a    = slots[4] > cfg.switch_mid_us;
            r.switch_b    = slots[5] > cfg.switch_mid_us;
            if (slots[6] < cfg.three_pos_low_us)
                r.switch_c = 2'd0;
            else if (slots[6] <= cfg.three_pos_high_us)
                r.switch_c = 2'd1;
            else
                r.switch_c = 2'd2;
            r.switch_d    = slots[7] > cfg.switch_mid_us;
            r.rc_lost     = armed && (slots[0] < cfg.lost_low_us ||
                                      slots[0] > cfg.lost_high_us);
            r.manual_hold = r.switch_a;
            return r;
        endfunction

        // Note an accepted input transaction
        function void take_transaction(ppmrc_pkg::op_t op, logic [31:0] stamp, logic armed);
            logic [31:0] width;
            if (op == ppmrc_pkg::OP_EDGE) begin
                width = (stamp - last_stamp) / TICKS;
                last_stamp = stamp;
                if (width > {16'd0, cfg.sync_threshold_us}) begin
                    slot_ptr = 0;
                end else if (slot_ptr < NUM_SLOTS) begin
                    slots[slot_ptr] = (width > 32'd4095) ? ppmrc_pkg::SLOT_MAX : width[11:0];
                    slot_ptr++;
                end
            end else begin
                pending_controls.push_back(map_slots(armed));
            end
        endfunction

        function void report(string what, int want, int got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        endfunction

        // Compare a result transaction with the oldest prediction
        function void check_controls(ppmrc_pkg::res_t got);
            ppmrc_pkg::res_t want;
            if (pending_controls.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result transaction %h", $time, got);
                return;
            end
            want = pending_controls.pop_front();
            if (got.throttle_tenths !== want.throttle_tenths)
                report("throttle_tenths", want.throttle_tenths, got.throttle_tenths);
            if (got.roll_steps !== want.roll_steps)
                report("roll_steps", want.roll_steps, got.roll_steps);
            if (got.pitch_steps !== want.pitch_steps)
                report("pitch_steps", want.pitch_steps, got.pitch_steps);
            if (got.yaw_steps !== want.yaw_steps)
                report("yaw_steps", want.yaw_steps, got.yaw_steps);
            if (got.switch_a !== want.switch_a)
                report("switch_a", want.switch_a, got.switch_a);
            if (got.switch_b !== want.switch_b)
                report("switch_b", want.switch_b, got.switch_b);
            if (got.switch_c !== want.switch_c)
                report("switch_c", want.switch_c, got.switch_c);
            if (got.switch_d !== want.switch_d)
                report("switch_d", want.switch_d, got.switch_d);
            if (got.rc_lost !== want.rc_lost)
                report("rc_lost", want.rc_lost, got.rc_lost);
            if (got.manual_hold !== want.manual_hold)
                report("manual_hold", want.manual_hold, got.manual_hold);
        endfunction

        function int outstanding();
            return pending_controls.size();
        endfunction
    endclass

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [39:0]                      s_tdata  = '0;    // edge_time[31:0], armed[32]
    logic                             s_tuser  = 1'b0;  // op[0]
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ppmrc_pkg::M_TDATA_W-1:0]  m_tdata;          // throttle .. manual_hold, see res_t
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [ppmrc_pkg::CFG_AW-1:0]     paddr    = '0;
    logic [ppmrc_pkg::CFG_DW-1:0]     pwdata   = '0;
    logic [ppmrc_pkg::CFG_DW-1:0]     prdata;
    logic                             pready;

    channel_map_tracker tracker = new();

    logic [31:0] edge_clock   = '0;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    int          sink_hold    = 0;
    bit          src_calm     = 1'b0;
    bit          sink_calm    = 1'b0;

    ppm_rc_channel_decoder #(
        .NUM_CHANNELS (NUM_SLOTS),
        .TICKS_PER_US (TICKS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: check each transaction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else begin
            if (m_tvalid && m_tready)
                tracker.check_controls(ppmrc_pkg::res_t'(m_tdata[ppmrc_pkg::RES_W-1:0]));
            if ($urandom_range(0, 79) == 0) sink_calm = !sink_calm;
            if (sink_hold != 0) begin
                m_tready  <= 1'b0;
                sink_hold <= sink_hold - 1;
            end else begin
                m_tready  <= 1'b1;
                sink_hold <= pick_gap(sink_calm);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send_item(ppmrc_pkg::op_t op, logic [31:0] stamp, logic armed);
        int unsigned gap;
        gap = pick_gap(src_calm);
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, armed, stamp};
        do @(posedge aclk); while (!s_tready);
        tracker.take_transaction(op, stamp, armed);
        if (op == ppmrc_pkg::OP_EDGE) edge_clock = stamp;
        items_sent++;
    endtask

    task automatic send_pulse(int unsigned us);
        logic [31:0] stamp;
        stamp = edge_clock + us * TICKS + $urandom_range(0, TICKS - 1);
        send_item(ppmrc_pkg::OP_EDGE, stamp, $urandom_range(0, 1));
    endtask

    task automatic send_poll(logic armed);
        send_item(ppmrc_pkg::OP_POLL, $urandom, armed);
    endtask

    // Drop valid, let the pipeline empty before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(ppmrc_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    task automatic apply_setting(ppmrc_pkg::cfg_t c);
        write_reg(ppmrc_pkg::REG_SYNC_THRESHOLD, 32'(c.sync_threshold_us));
        write_reg(ppmrc_pkg::REG_LOST_LOW,       32'(c.lost_low_us));
        write_reg(ppmrc_pkg::REG_LOST_HIGH,      32'(c.lost_high_us));
        write_reg(ppmrc_pkg::REG_DZ_ROLL_PITCH,  32'(c.deadzone_roll_pitch));
        write_reg(ppmrc_pkg::REG_DZ_YAW,         32'(c.yaw_deadband));
        write_reg(ppmrc_pkg::REG_SWITCH_MID,     32'(c.switch_mid_us));
        write_reg(ppmrc_pkg::REG_THREE_POS_LOW,  32'(c.three_pos_low_us));
        write_reg(ppmrc_pkg::REG_THREE_POS_HIGH, 32'(c.three_pos_high_us));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic ppmrc_pkg::cfg_t random_setting();
        ppmrc_pkg::cfg_t c;
        c.sync_threshold_us   = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                            : 16'($urandom_range(2100, 8000));
        c.lost_low_us         = 12'($urandom_range(0, 1200));
        c.lost_high_us        = 12'($urandom_range(1800, 4095));
        c.deadzone_roll_pitch = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1500))
                                                            : 11'($urandom_range(0, 60));
        c.yaw_deadband        = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1500))
                                                            : 11'($urandom_range(0, 60));
        c.switch_mid_us       = 12'($urandom_range(1000, 2000));
        c.three_pos_low_us    = 12'($urandom_range(900, 1600));
        c.three_pos_high_us   = 12'($urandom_range(1400, 2100));
        return c;
    endfunction

    // Channel width: mostly stick travel, often right at a threshold
    function automatic int unsigned pick_width();
        int unsigned r;
        int b;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(950, 2050);
        if (r < 70) begin
            case ($urandom_range(0, 9))
                0: b = tracker.cfg.lost_low_us;
                1: b = tracker.cfg.lost_high_us;
                2: b = tracker.cfg.switch_mid_us;
                3: b = tracker.cfg.three_pos_low_us;
                4: b = tracker.cfg.three_pos_high_us;
                5: b = 1000;
                6: b = 2000;
                7: b = 1500 + int'(tracker.cfg.deadzone_roll_pitch);
                8: b = 1500 - int'(tracker.cfg.deadzone_roll_pitch);
                default: b = ($urandom_range(0, 1) == 0) ?
                             1500 + int'(tracker.cfg.yaw_deadband) :
                             1500 - int'(tracker.cfg.yaw_deadband);
            endcase
            return (b < 1) ? $urandom_range(0, 1) : b - 1 + $urandom_range(0, 2);
        end
        if (r < 85) return $urandom_range(0, 4095);
        if (r < 92) return tracker.cfg.sync_threshold_us;
        return $urandom_range(0, 65535);
    endfunction

    // Sync pulse, a run of channel pulses, polls in between and usually at the end
    task automatic send_frame();
        int unsigned n;
        if ($urandom_range(0, 4) == 0)
            send_item(ppmrc_pkg::OP_EDGE, $urandom, $urandom_range(0, 1));
        send_pulse(tracker.cfg.sync_threshold_us +
                   (($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 3000)));
        n = ($urandom_range(0, 9) < 6) ? NUM_SLOTS : $urandom_range(0, NUM_SLOTS + 3);
        repeat (n) begin
            send_pulse(pick_width());
            if ($urandom_range(0, 9) == 0) send_poll($urandom_range(0, 1));
        end
        if ($urandom_range(0, 9) < 7) send_poll($urandom_range(0, 1));
    endtask

    initial begin : main
        ppmrc_pkg::cfg_t c;
        int              target;
        int unsigned     r;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Slots straight after reset: all zero
        send_poll(1'b1);
        // Full frame at range limits and thresholds
        send_pulse(4000);
        send_pulse(799);
        send_pulse(0);
        send_pulse(2100);
        send_pulse(1514);
        send_pulse(1501);
        send_pulse(1500);
        send_pulse(1300);
        send_pulse(1701);
        // Ninth pulse is dropped
        send_pulse(1700);
        send_poll(1'b1);
        send_poll(1'b0);
        // Short frame: pulse just over the threshold, deadzone edges
        send_pulse(3001);
        send_pulse(2201);
        send_pulse(1510);
        send_pulse(1000);
        send_pulse(1485);
        send_poll(1'b1);

        // Widest threshold: over-long pulses saturate in their slot
        settle();
        c = tracker.cfg;
        c.sync_threshold_us = 16'hFFFF;
        apply_setting(c);
        send_pulse(70000);
        send_pulse(5000);
        send_pulse(65535);
        send_pulse(1);
        send_pulse(4095);
        send_poll(1'b1);
        // Timer wrap inside a pulse
        send_item(ppmrc_pkg::OP_EDGE, 32'hFFFF_FF00, 1'b1);
        send_pulse(2000);
        send_poll(1'b0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: c = '{sync_threshold_us: ppmrc_pkg::RST_SYNC_THRESHOLD,
                         lost_low_us: ppmrc_pkg::RST_LOST_LOW,
                         lost_high_us: ppmrc_pkg::RST_LOST_HIGH,
                         deadzone_roll_pitch: ppmrc_pkg::RST_DZ_ROLL_PITCH,
                         yaw_deadband: ppmrc_pkg::RST_DZ_YAW,
                         switch_mid_us: ppmrc_pkg::RST_SWITCH_MID,
                         three_pos_low_us: ppmrc_pkg::RST_THREE_POS_LOW,
                         three_pos_high_us: ppmrc_pkg::RST_THREE_POS_HIGH};
                1: c = '0;
                2: c = '{sync_threshold_us: 16'hFFFF, lost_low_us: 12'hFFF,
                         lost_high_us: 12'hFFF, deadzone_roll_pitch: 11'd1500,
                         yaw_deadband: 11'd1500, switch_mid_us: 12'hFFF,
                         three_pos_low_us: 12'hFFF, three_pos_high_us: 12'hFFF};
                default: c = random_setting();
            endcase
            apply_setting(c);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_frame();
                else if (r < 85)
                    send_item(ppmrc_pkg::OP_EDGE, $urandom, $urandom_range(0, 1));
                else if (r < 95)
                    send_poll($urandom_range(0, 1));
                else
                    send_pulse(pick_width());
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/ppmrc_pkg.sv
sv/ppmrc_cfg_regs.sv
sv/ppmrc_width_meas.sv
sv/ppmrc_chan_map.sv
sv/ppm_rc_channel_decoder.sv
dv/tb_ppm_rc_channel_decoder.sv
